// ===== src/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// rme_pkg
// Shared widths, register codes and controller/datapath command types for the
// modular exponentiation decrypt block.
// ----------------------------------------------------------------------------
package rme_pkg;

   // field and register widths
   localparam int RME_WORD_WIDTH      = 32;
   localparam int RME_CIPHER_WIDTH    = 32;
   localparam int RME_CODE_WIDTH      = 33;
   localparam int RME_EXP_WIDTH       = 32;
   localparam int RME_EXP_COUNT_WIDTH = $clog2(RME_EXP_WIDTH);
   localparam int RME_REG_WIDTH       = 32;
   localparam int RME_ADDR_WIDTH      = 3;

   // offset added to every plaintext code
   localparam logic [RME_CODE_WIDTH-1:0] RME_CODE_OFFSET = 33'd96;

   // register index, taken from the word address
   typedef enum logic [0:0] {
      RME_REG_MODULUS  = 1'b0,
      RME_REG_EXPONENT = 1'b1
   } rme_reg_type;

   // kind of modular multiplication run by the datapath
   typedef enum logic [1:0] {
      MUL_REDUCE,
      MUL_SQUARE,
      MUL_MULT
   } mul_op_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;
      logic       mul_start;
      mul_op_type mul_op;
      logic       mul_step;
      logic       store_base;
      logic       store_result;
      logic       exp_shift;
      logic       out_load;
   } rme_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic exp_zero;
      logic exp_bit;
   } rme_status_type;

endpackage

// ===== src/rme_if.sv =====
// ----------------------------------------------------------------------------
// rme channel interfaces
// Valid/ready channels for ciphertext words in and plaintext codes out.
// ----------------------------------------------------------------------------
interface rme_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [rme_pkg::RME_CIPHER_WIDTH-1:0] cipher_value;
   logic                                 last;

   modport source (output valid, output cipher_value, output last, input ready);
   modport sink   (input valid, input cipher_value, input last, output ready);
endinterface

interface rme_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rme_pkg::RME_CODE_WIDTH-1:0] plain_code;
   logic                               last_out;

   modport source (output valid, output plain_code, output last_out, input ready);
   modport sink   (input valid, input plain_code, input last_out, output ready);
endinterface

// ===== src/rme_csr.sv =====
// ----------------------------------------------------------------------------
// rme_csr
// APB-style register file holding the modulus and the private exponent.
// ----------------------------------------------------------------------------
module rme_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rme_pkg::RME_ADDR_WIDTH-1:0]  paddr,
   input  logic [rme_pkg::RME_REG_WIDTH-1:0]   pwdata,
   output logic [rme_pkg::RME_REG_WIDTH-1:0]   prdata,
   output logic                                pready,
   output logic [rme_pkg::RME_REG_WIDTH-1:0]   modulus,
   output logic [rme_pkg::RME_EXP_WIDTH-1:0]   private_exponent
);
   import rme_pkg::*;

   logic [RME_REG_WIDTH-1:0] modulus_ff;
   logic [RME_EXP_WIDTH-1:0] exponent_ff;
   rme_reg_type              reg_sel;
   logic                     wr_en;

   assign reg_sel = rme_reg_type'(paddr[RME_ADDR_WIDTH-1]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // register writes in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= RME_REG_WIDTH'(2);
         exponent_ff <= RME_EXP_WIDTH'(1);
      end else if (wr_en) begin
         case (reg_sel)
            RME_REG_MODULUS:  modulus_ff  <= pwdata;
            RME_REG_EXPONENT: exponent_ff <= pwdata;
            default:          modulus_ff  <= modulus_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         RME_REG_MODULUS:  prdata = modulus_ff;
         RME_REG_EXPONENT: prdata = exponent_ff;
         default:          prdata = '0;
      endcase
   end

   assign modulus          = modulus_ff;
   assign private_exponent = exponent_ff;

endmodule

// ===== src/rme_dp.sv =====
// ----------------------------------------------------------------------------
// rme_dp
// Exponentiation datapath: base, running power, exponent shifter and a
// bit-serial interleaved multiply-and-reduce unit, plus the result register.
// ----------------------------------------------------------------------------
module rme_dp #(
   parameter int WORD_WIDTH = rme_pkg::RME_WORD_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rme_pkg::rme_cmd_type                  cmd,
   output rme_pkg::rme_status_type               status,
   input  logic [rme_pkg::RME_REG_WIDTH-1:0]     modulus,
   input  logic [rme_pkg::RME_EXP_WIDTH-1:0]     private_exponent,
   input  logic [rme_pkg::RME_CIPHER_WIDTH-1:0]  cipher_value,
   input  logic                                  last,
   output logic [rme_pkg::RME_CODE_WIDTH-1:0]    plain_code,
   output logic                                  last_out
);
   import rme_pkg::*;

   localparam int SUM_WIDTH = WORD_WIDTH + 2;

   logic [WORD_WIDTH-1:0]     base_ff,   base_in;
   logic [WORD_WIDTH-1:0]     result_ff, result_in;
   logic [WORD_WIDTH-1:0]     acc_ff,    acc_in;
   logic [WORD_WIDTH-1:0]     mul_a_ff,  mul_a_in;
   logic [WORD_WIDTH-1:0]     mul_b_ff,  mul_b_in;
   logic [RME_EXP_WIDTH-1:0]  exp_ff,    exp_in;
   logic                      last_ff,   last_in;
   logic [RME_CODE_WIDTH-1:0] code_ff,   code_in;
   logic                      last_out_ff, last_out_in;

   logic [WORD_WIDTH-1:0] mod_w;
   logic                  mod_zero;
   logic [SUM_WIDTH-1:0]  step_sum;
   logic [SUM_WIDTH-1:0]  mod_x1;
   logic [SUM_WIDTH-1:0]  mod_x2;
   logic [WORD_WIDTH-1:0] step_acc;

   assign mod_w    = modulus[WORD_WIDTH-1:0];
   assign mod_zero = (mod_w == '0);
   assign mod_x1   = SUM_WIDTH'(mod_w);
   assign mod_x2   = {1'b0, mod_w, 1'b0};

   // one multiplier bit: acc = 2*acc + bit*b, then bring back below 3m -> below m
   always_comb begin
      step_sum = {1'b0, acc_ff, 1'b0}
               + (mul_a_ff[WORD_WIDTH-1] ? SUM_WIDTH'(mul_b_ff) : SUM_WIDTH'(0));
      if (mod_zero) begin
         step_acc = step_sum[WORD_WIDTH-1:0];
      end else if (step_sum >= mod_x2) begin
         step_acc = WORD_WIDTH'(step_sum - mod_x2);
      end else if (step_sum >= mod_x1) begin
         step_acc = WORD_WIDTH'(step_sum - mod_x1);
      end else begin
         step_acc = step_sum[WORD_WIDTH-1:0];
      end
   end

   // operand setup and stepping of the multiplier
   always_comb begin
      acc_in   = acc_ff;
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      if (cmd.mul_start) begin
         acc_in = '0;
         case (cmd.mul_op)
            MUL_REDUCE: begin
               mul_a_in = base_ff;
               mul_b_in = WORD_WIDTH'(1);
            end
            MUL_SQUARE: begin
               mul_a_in = result_ff;
               mul_b_in = result_ff;
            end
            MUL_MULT: begin
               mul_a_in = result_ff;
               mul_b_in = base_ff;
            end
            default: begin
               mul_a_in = '0;
               mul_b_in = '0;
            end
         endcase
      end else if (cmd.mul_step) begin
         acc_in   = step_acc;
         mul_a_in = {mul_a_ff[WORD_WIDTH-2:0], 1'b0};
      end
   end

   // item state: base, power, exponent bits, last flag
   always_comb begin
      base_in   = base_ff;
      result_in = result_ff;
      exp_in    = exp_ff;
      last_in   = last_ff;
      if (cmd.load) begin
         base_in   = cipher_value[WORD_WIDTH-1:0];
         result_in = WORD_WIDTH'(1);
         exp_in    = private_exponent;
         last_in   = last;
      end else begin
         if (cmd.store_base) begin
            base_in = step_acc;
         end
         if (cmd.store_result) begin
            result_in = step_acc;
         end
         if (cmd.exp_shift) begin
            exp_in = {exp_ff[RME_EXP_WIDTH-2:0], 1'b0};
         end
      end
   end

   // output register
   always_comb begin
      code_in     = code_ff;
      last_out_in = last_out_ff;
      if (cmd.out_load) begin
         code_in     = RME_CODE_WIDTH'(result_ff) + RME_CODE_OFFSET;
         last_out_in = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      result_ff   <= result_in;
      acc_ff      <= acc_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      exp_ff      <= exp_in;
      last_ff     <= last_in;
      code_ff     <= code_in;
      last_out_ff <= last_out_in;
   end

   assign status.exp_zero = (private_exponent == '0);
   assign status.exp_bit  = exp_ff[RME_EXP_WIDTH-1];
   assign plain_code      = code_ff;
   assign last_out        = last_out_ff;

   // checks
   a_load_power_one: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (result_ff == WORD_WIDTH'(1)))
      else $error("power not set to one after load");

   a_start_clears_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> (acc_ff == '0))
      else $error("accumulator not cleared at multiply start");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (last_out_ff == $past(last_ff)))
      else $error("last flag lost on output load");

endmodule

// ===== src/rme_ctrl.sv =====
// ----------------------------------------------------------------------------
// rme_ctrl
// Controller: accepts a word, sequences base reduction, then square and
// conditional multiply for each exponent bit, and hands the code to the
// output register. A zero exponent goes straight to the output register.
// ----------------------------------------------------------------------------
module rme_ctrl #(
   parameter int WORD_WIDTH = rme_pkg::RME_WORD_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rme_pkg::rme_status_type  status,
   output rme_pkg::rme_cmd_type     cmd
);
   import rme_pkg::*;

   localparam int STEP_WIDTH = $clog2(WORD_WIDTH);
   localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(WORD_WIDTH - 1);
   localparam logic [RME_EXP_COUNT_WIDTH-1:0] BIT_LAST =
      RME_EXP_COUNT_WIDTH'(RME_EXP_WIDTH - 1);

   typedef enum logic [1:0] {
      IDLE,
      START,
      MUL,
      FINISH
   } state_type;

   state_type                      state_ff,     state_in;
   mul_op_type                     op_ff,        op_in;
   logic [STEP_WIDTH-1:0]          step_ff,      step_in;
   logic [RME_EXP_COUNT_WIDTH-1:0] bit_ff,       bit_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           bit_done;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      bit_done     = 1'b0;
      cmd          = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               bit_in   = '0;
               op_in    = MUL_REDUCE;
               state_in = status.exp_zero ? FINISH : START;
            end
         end
         START: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = op_ff;
            step_in       = '0;
            state_in      = MUL;
         end
         MUL: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               case (op_ff)
                  MUL_REDUCE: begin
                     cmd.store_base = 1'b1;
                     op_in          = MUL_SQUARE;
                     state_in       = START;
                  end
                  MUL_SQUARE: begin
                     cmd.store_result = 1'b1;
                     if (status.exp_bit) begin
                        op_in    = MUL_MULT;
                        state_in = START;
                     end else begin
                        bit_done = 1'b1;
                     end
                  end
                  MUL_MULT: begin
                     cmd.store_result = 1'b1;
                     bit_done         = 1'b1;
                  end
                  default: begin
                     state_in = IDLE;
                  end
               endcase
            end
         end
         FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      // move on to the next exponent bit
      if (bit_done) begin
         cmd.exp_shift = 1'b1;
         bit_in        = bit_ff + 1'b1;
         op_in         = MUL_SQUARE;
         state_in      = (bit_ff == BIT_LAST) ? FINISH : START;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         op_ff        <= MUL_REDUCE;
         step_ff      <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready still high after accepting a beat");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MUL) |-> (step_ff <= STEP_LAST))
      else $error("multiplier step count out of range");

   a_store_then_next: assert property (@(posedge clock) disable iff (reset)
      cmd.store_result |=> (state_ff == START || state_ff == FINISH))
      else $error("unexpected state after storing the power");

endmodule

// ===== src/rsa_modular_exponent_decrypt.sv =====
// ----------------------------------------------------------------------------
// rsa_modular_exponent_decrypt
// Each ciphertext beat returns (cipher ^ exponent mod modulus) + 96 with the
// last flag copied; a zero exponent gives a power of one, never reduced. One
// word is processed at a time, and the pace is set by the bit-serial
// multiply-and-reduce unit: one multiplier bit a cycle, one base reduction
// plus a square for each of the 32 exponent bits and a multiply for each set
// bit. The next beat is taken while a finished code still waits in the output
// register. Modulus (0x0) and private exponent (0x4) are written over the APB
// port; the user must write them only while the block is idle, and the block
// itself does not enforce this. A zero modulus means arithmetic modulo
// 2^WORD_WIDTH.
// ----------------------------------------------------------------------------
module rsa_modular_exponent_decrypt #(
   parameter int WORD_WIDTH = rme_pkg::RME_WORD_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   rme_req_if.sink                             req,
   rme_rsp_if.source                           rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [rme_pkg::RME_ADDR_WIDTH-1:0]  paddr,
   input  logic [rme_pkg::RME_REG_WIDTH-1:0]   pwdata,
   output logic [rme_pkg::RME_REG_WIDTH-1:0]   prdata,
   output logic                                pready
);
   import rme_pkg::*;

   logic [RME_REG_WIDTH-1:0] modulus;
   logic [RME_EXP_WIDTH-1:0] private_exponent;
   rme_cmd_type              cmd;
   rme_status_type           status;

   // configuration registers
   rme_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .modulus          (modulus),
      .private_exponent (private_exponent)
   );

   // sequencing
   rme_ctrl #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and output register
   rme_dp #(
      .WORD_WIDTH (WORD_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .modulus          (modulus),
      .private_exponent (private_exponent),
      .cipher_value     (req.cipher_value),
      .last             (req.last),
      .plain_code       (rsp.plain_code),
      .last_out         (rsp.last_out)
   );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rsa_modular_exponent_decrypt. Ciphertext beats go in
// over the req channel while a local square-and-multiply predictor computes
// each expected plain code from its own copy of the key registers. Results
// are compared in order as they leave the rsp channel. Keys are written and
// read back over the APB port between runs of beats, only while the block is
// idle. Directed runs cover zero exponent, modulus zero and one, oversized
// ciphers and full-width keys. Random runs cover varied keys with sender gaps
// and receiver stalls, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb;
   import rme_pkg::*;

   localparam int WW            = RME_WORD_WIDTH;
   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 40;
   localparam int LIMIT_CYCLES  = 4_000_000;
   localparam int HOLD_CYCLES   = 6000;

   typedef struct packed {
      logic [RME_CODE_WIDTH-1:0] plain_code;
      logic                      last_out;
   } plain_beat_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [RME_ADDR_WIDTH-1:0] paddr;
   logic [RME_REG_WIDTH-1:0]  pwdata;
   logic [RME_REG_WIDTH-1:0]  prdata;
   logic                      pready;

   rme_req_if req_bus ();
   rme_rsp_if rsp_bus ();

   rsa_modular_exponent_decrypt i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // local copy of the key registers, reset values
   logic [RME_REG_WIDTH-1:0] key_modulus  = 32'd2;
   logic [RME_REG_WIDTH-1:0] key_exponent = 32'd1;

   plain_beat_type plain_q[$];
   int             errors        = 0;
   int             beats_sent    = 0;
   int             codes_checked = 0;
   int             key_writes    = 0;
   int             send_idle_pct = 0;
   int             stall_pct     = 0;

   // long hold-off request, handed to the receiver by a toggle
   bit hold_go   = 1'b0;
   bit hold_ack  = 1'b0;
   int hold_len  = 0;
   int hold_left = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // one modular product, wrapping at the word width for modulus zero
   function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
      logic [63:0] prod;
      prod = 64'(a[WW-1:0]) * 64'(b[WW-1:0]);
      if (m == 64'd0) return 64'(prod[WW-1:0]);
      return prod % m;
   endfunction

   // expected plain code for one cipher word under the current key
   function automatic plain_beat_type decrypt_beat(logic [RME_CIPHER_WIDTH-1:0] cipher,
                                                   logic last_in);
      logic [63:0]    m;
      logic [63:0]    base;
      logic [63:0]    acc;
      plain_beat_type beat;
      m = 64'(key_modulus[WW-1:0]);
      if (key_exponent == '0) begin
         // zero exponent: power is one, never reduced
         acc = 64'd1;
      end else begin
         if (m == 64'd0) begin
            base = 64'(cipher[WW-1:0]);
            acc  = 64'd1;
         end else begin
            base = 64'(cipher[WW-1:0]) % m;
            acc  = 64'd1 % m;
         end
         for (int i = RME_EXP_WIDTH - 1; i >= 0; i--) begin
            acc = mul_mod(acc, acc, m);
            if (key_exponent[i]) acc = mul_mod(acc, base, m);
         end
      end
      beat.plain_code = RME_CODE_OFFSET + acc[RME_CODE_WIDTH-1:0];
      beat.last_out   = last_in;
      return beat;
   endfunction

   // key value with the extremes weighted in
   function automatic logic [31:0] pick_key_word();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'hFFFF_FFFF;
         3: return 32'($urandom_range(1000, 2));
         default: return 32'($urandom);
      endcase
   endfunction

   // cipher word, often near or above the modulus
   function automatic logic [31:0] pick_cipher();
      case ($urandom_range(11))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return key_modulus;
         3: return key_modulus - 32'd1;
         4: return (key_modulus == '0) ? 32'($urandom) : 32'($urandom) % key_modulus;
         default: return 32'($urandom);
      endcase
   endfunction

   // result check against the oldest expected code
   always @(posedge clock) begin : check_codes
      plain_beat_type want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (plain_q.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got code %h last %b",
                     $time, rsp_bus.plain_code, rsp_bus.last_out);
            errors++;
         end else begin
            want = plain_q.pop_front();
            codes_checked++;
            if (rsp_bus.plain_code !== want.plain_code) begin
               $display("%0t: plain_code expected %h got %h",
                        $time, want.plain_code, rsp_bus.plain_code);
               errors++;
            end
            if (rsp_bus.last_out !== want.last_out) begin
               $display("%0t: last_out expected %b got %b",
                        $time, want.last_out, rsp_bus.last_out);
               errors++;
            end
         end
      end
   end

   // receiver ready: random stalls, or a counted hold-off on request
   always @(posedge clock) begin
      if (hold_go != hold_ack) begin
         hold_ack      <= hold_go;
         hold_left     <= hold_len;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // run ends here at the latest
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct <= 0;  end
         IDLE_SENDER:   begin send_idle_pct = 68; stall_pct <= 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct <= 68; end
         default:       begin send_idle_pct = 25; stall_pct <= 25; end
      endcase
   endtask

   // offer one cipher beat, record its expected code once accepted
   task automatic send_beat(logic [31:0] cipher, logic last_in);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cipher_value <= cipher;
      req_bus.last         <= last_in;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      plain_q.push_back(decrypt_beat(cipher, last_in));
      beats_sent++;
   endtask

   // stop offering and wait until every expected code is out
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (plain_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_reg(rme_reg_type sel, logic [31:0] want);
      logic [31:0] got;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {sel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== want) begin
         $display("%0t: register %s read expected %h got %h", $time, sel.name(), want, got);
         errors++;
      end
   endtask

   // key write while idle, then read back
   task automatic write_reg(rme_reg_type sel, logic [31:0] value);
      wait_idle();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (sel == RME_REG_MODULUS) key_modulus = value;
      else key_exponent = value;
      key_writes++;
      check_reg(sel, value);
   endtask

   task automatic test_reset_key();
      check_reg(RME_REG_MODULUS, 32'd2);
      check_reg(RME_REG_EXPONENT, 32'd1);
      send_beat(32'd0, 1'b0);
      send_beat(32'd1, 1'b0);
      send_beat(32'd2, 1'b0);
      send_beat(32'hFFFF_FFFF, 1'b1);
   endtask

   // power of one whatever the modulus, modulus one and zero included
   task automatic test_zero_exponent();
      write_reg(RME_REG_EXPONENT, 32'd0);
      write_reg(RME_REG_MODULUS, 32'hFFFF_FFFF);
      send_beat(32'd0, 1'b0);
      send_beat(32'hFFFF_FFFF, 1'b1);
      write_reg(RME_REG_MODULUS, 32'd1);
      send_beat(32'd12345, 1'b0);
      write_reg(RME_REG_MODULUS, 32'd0);
      send_beat(32'd7, 1'b1);
   endtask

   // every power reduces to zero
   task automatic test_unit_modulus();
      write_reg(RME_REG_MODULUS, 32'd1);
      write_reg(RME_REG_EXPONENT, 32'hFFFF_FFFF);
      send_beat(32'hFFFF_FFFF, 1'b0);
      send_beat(32'd0, 1'b1);
   endtask

   // no reduction, power wraps at the word width
   task automatic test_zero_modulus();
      write_reg(RME_REG_MODULUS, 32'd0);
      send_beat(32'd3, 1'b0);
      send_beat(32'hFFFF_FFFF, 1'b0);
      send_beat(32'd2, 1'b1);
   endtask

   // small textbook key, ciphers below, at and above the modulus
   task automatic test_textbook_key();
      write_reg(RME_REG_MODULUS, 32'd3233);
      write_reg(RME_REG_EXPONENT, 32'd2753);
      send_beat(32'd2790, 1'b0);
      send_beat(32'd5000, 1'b0);
      send_beat(32'd3233, 1'b1);
   endtask

   task automatic test_wide_key();
      write_reg(RME_REG_MODULUS, 32'hFFFF_FFFF);
      write_reg(RME_REG_EXPONENT, 32'hFFFF_FFFF);
      send_beat(32'hFFFF_FFFE, 1'b0);
      send_beat(32'hFFFF_FFFF, 1'b0);
      send_beat(32'h8000_0000, 1'b1);
   endtask

   // receiver held off long enough for the block to stall its input
   task automatic test_output_backpressure();
      set_idling(IDLE_NONE);
      write_reg(RME_REG_MODULUS, 32'hFFFF_FFFB);
      write_reg(RME_REG_EXPONENT, 32'd3);
      hold_len <= HOLD_CYCLES;
      hold_go  <= ~hold_go;
      repeat (6) send_beat(pick_cipher(), $urandom_range(1));
      wait_idle();
   endtask

   // random keys, one idling mode per run of beats
   task automatic test_random_keys(int runs, int beats_per_run);
      for (int r = 0; r < runs; r++) begin
         write_reg(RME_REG_MODULUS, pick_key_word());
         write_reg(RME_REG_EXPONENT, pick_key_word());
         set_idling(idle_mode_type'(r % 4));
         repeat (beats_per_run) send_beat(pick_cipher(), $urandom_range(7) == 0);
      end
      set_idling(IDLE_NONE);
   endtask

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.cipher_value <= '0;
      req_bus.last         <= 1'b0;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_key();
      test_zero_exponent();
      test_unit_modulus();
      test_zero_modulus();
      test_textbook_key();
      test_wide_key();
      test_output_backpressure();
      test_random_keys(8, 33);

      wait_idle();
      $display("sent %0d cipher beats under %0d key writes, %0d codes checked",
               beats_sent, key_writes, codes_checked);
      $display("covered zero exponent, modulus zero and one, full-width keys, stalls");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
